// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the key debounce block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define KDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define KDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kdr_pkg.sv =====
// Types, codes and constants of the key debounce / event FIFO block.
// No dependencies; used by the interface, config, scan, FIFO and top-level files through scoped names.
package kdr_pkg;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned TICK_W = 16;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_REPEAT   = 1'b1;

  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [TICK_W-1:0] REPEAT_RST   = 16'd250;
  localparam logic [TICK_W-1:0] ELAPSED_MAX  = 16'hFFFF;

  // Item commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Key codes
  localparam int unsigned KEY_W = 3;
  localparam logic [KEY_W-1:0] CODE_NONE   = 3'd0;
  localparam logic [KEY_W-1:0] CODE_SET    = 3'd1;
  localparam logic [KEY_W-1:0] CODE_PLUS   = 3'd2;
  localparam logic [KEY_W-1:0] CODE_MINUS  = 3'd3;
  localparam logic [KEY_W-1:0] CODE_RETURN = 3'd4;

  // Event kinds
  typedef enum logic [1:0] {
    KIND_PRESSED  = 2'd0,
    KIND_REPEATED = 2'd1,
    KIND_RELEASED = 2'd2
  } kind_e;

  // Scan phases, one-hot
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_DEBOUNCE = 4'b0010,
    PH_HELD     = 4'b0100,
    PH_RELEASE  = 4'b1000
  } phase_e;

  // One stored event: key in the upper bits, kind in the lower two
  localparam int unsigned EVT_W = KEY_W + 2;

  // Push request from the scanner to the FIFO
  typedef struct packed {
    logic             push;
    logic [KEY_W-1:0] key;
    kind_e            kind;
  } push_t;

  // FIFO status toward the result stage
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Fixed-priority scan of active-low pins
  function automatic logic [KEY_W-1:0] scan_keys(input logic [3:0] levels);
    logic [KEY_W-1:0] code;
    code = CODE_NONE;
    priority if (!levels[0]) code = CODE_SET;
    else if (!levels[1])     code = CODE_PLUS;
    else if (!levels[2])     code = CODE_MINUS;
    else if (!levels[3])     code = CODE_RETURN;
    else                     code = CODE_NONE;
    return code;
  endfunction

endpackage

// ===== rtl/kdr_if.sv =====
// Handshake channel interfaces of the key debounce block.
// Depends on kdr_pkg for field widths.
interface kdr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] key_levels;

  modport source (output valid, output cmd, output key_levels, input ready);
  modport sink   (input valid, input cmd, input key_levels, output ready);
endinterface

interface kdr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      event_valid;
  logic [kdr_pkg::KEY_W-1:0] event_key;
  logic [1:0]                event_kind;
  logic                      event_dropped;

  modport source (output valid, output event_valid, output event_key,
                  output event_kind, output event_dropped, input ready);
  modport sink   (input valid, input event_valid, input event_key,
                  input event_kind, input event_dropped, output ready);
endinterface

// ===== rtl/kdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kdr_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kdr_cfg.sv =====
// APB-style configuration registers: debounce and repeat tick counts.
// Depends on kdr_pkg for widths, register indexes and reset values.
module kdr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kdr_pkg::CFG_AW-1:0]  paddr,
  input  logic [kdr_pkg::CFG_DW-1:0]  pwdata,
  output logic [kdr_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [kdr_pkg::TICK_W-1:0] debounce_ticks_o,
  output logic [kdr_pkg::TICK_W-1:0] repeat_ticks_o
);

  logic [kdr_pkg::TICK_W-1:0] debounce_q;
  logic [kdr_pkg::TICK_W-1:0] repeat_q;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kdr_pkg::DEBOUNCE_RST;
      repeat_q   <= kdr_pkg::REPEAT_RST;
    end else if (wr_en) begin
      if (reg_sel == kdr_pkg::REG_DEBOUNCE) begin
        debounce_q <= pwdata[kdr_pkg::TICK_W-1:0];
      end else begin
        repeat_q <= pwdata[kdr_pkg::TICK_W-1:0];
      end
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    if (reg_sel == kdr_pkg::REG_DEBOUNCE) begin
      prdata[kdr_pkg::TICK_W-1:0] = debounce_q;
    end else begin
      prdata[kdr_pkg::TICK_W-1:0] = repeat_q;
    end
  end

  assign debounce_ticks_o = debounce_q;
  assign repeat_ticks_o   = repeat_q;

endmodule

// ===== rtl/kdr_scan.sv =====
// Key scan state machine: debounce, hold with auto-repeat, release check.
// Depends on kdr_pkg for phase/kind enums, key codes and the push struct.
module kdr_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic [3:0]                  key_levels_i,
  input  logic [kdr_pkg::TICK_W-1:0] debounce_ticks_i,
  input  logic [kdr_pkg::TICK_W-1:0] repeat_ticks_i,
  output kdr_pkg::push_t              push_o
);

  kdr_pkg::phase_e              phase_q, phase_d;
  logic [kdr_pkg::KEY_W-1:0]    held_q, held_d;
  logic [kdr_pkg::TICK_W-1:0]   elapsed_q, elapsed_d;
  logic [kdr_pkg::TICK_W-1:0]   elapsed_inc;
  logic [kdr_pkg::KEY_W-1:0]    code;
  logic                         push;
  kdr_pkg::kind_e               kind;

  assign code = kdr_pkg::scan_keys(key_levels_i);

  // Saturating elapsed count, advanced in every phase but idle
  assign elapsed_inc = (phase_q != kdr_pkg::PH_IDLE && elapsed_q != kdr_pkg::ELAPSED_MAX)
                     ? elapsed_q + kdr_pkg::TICK_W'(1) : elapsed_q;

  // Next-state logic for one tick
  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    elapsed_d = elapsed_inc;
    push      = 1'b0;
    kind      = kdr_pkg::KIND_PRESSED;
    unique case (phase_q)
      kdr_pkg::PH_IDLE: begin
        if (code != kdr_pkg::CODE_NONE) begin
          held_d    = code;
          elapsed_d = '0;
          phase_d   = kdr_pkg::PH_DEBOUNCE;
        end
      end
      kdr_pkg::PH_DEBOUNCE: begin
        if (elapsed_inc >= debounce_ticks_i) begin
          if (code == held_q) begin
            push      = 1'b1;
            kind      = kdr_pkg::KIND_PRESSED;
            elapsed_d = '0;
            phase_d   = kdr_pkg::PH_HELD;
          end else begin
            phase_d = kdr_pkg::PH_IDLE;
          end
        end
      end
      kdr_pkg::PH_HELD: begin
        if (code == kdr_pkg::CODE_NONE) begin
          elapsed_d = '0;
          phase_d   = kdr_pkg::PH_RELEASE;
        end else if (elapsed_inc > repeat_ticks_i) begin
          push      = 1'b1;
          kind      = kdr_pkg::KIND_REPEATED;
          elapsed_d = '0;
        end
      end
      kdr_pkg::PH_RELEASE: begin
        if (elapsed_inc >= debounce_ticks_i) begin
          if (code == kdr_pkg::CODE_NONE) begin
            push    = 1'b1;
            kind    = kdr_pkg::KIND_RELEASED;
            phase_d = kdr_pkg::PH_IDLE;
          end else begin
            elapsed_d = '0;
          end
        end
      end
      default: begin
        phase_d = kdr_pkg::PH_IDLE;
      end
    endcase
  end

  // State advances on accepted tick transactions only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= kdr_pkg::PH_IDLE;
      held_q    <= kdr_pkg::CODE_NONE;
      elapsed_q <= '0;
    end else if (tick_i) begin
      phase_q   <= phase_d;
      held_q    <= held_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign push_o.push = tick_i && push;
  assign push_o.key  = held_q;
  assign push_o.kind = kind;

endmodule

// ===== rtl/kdr_fifo.sv =====
// Ring FIFO of key events that keeps one slot free; storage in kdr_ram.
// Depends on kdr_pkg and kdr_ram.
module kdr_fifo #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kdr_pkg::push_t             push_i,
  input  logic                       pop_i,
  output kdr_pkg::fifo_stat_t        stat_o,
  output logic [kdr_pkg::EVT_W-1:0]  rdata_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

  logic [AW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [AW-1:0] rd_next, wr_next;
  logic          wr_en, rd_en;

  assign rd_next = (rd_q == LAST) ? '0 : rd_q + AW'(1);
  assign wr_next = (wr_q == LAST) ? '0 : wr_q + AW'(1);

  assign stat_o.empty = (rd_q == wr_q);
  assign stat_o.full  = (wr_next == rd_q);

  assign wr_en = push_i.push && !stat_o.full;
  assign rd_en = pop_i && !stat_o.empty;

  assign rd_d = rd_en ? rd_next : rd_q;
  assign wr_d = wr_en ? wr_next : wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  // Event storage; read data lands in the RAM output register
  kdr_ram #(
    .WIDTH (kdr_pkg::EVT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_q),
    .wdata_i ({push_i.key, push_i.kind}),
    .re_i    (rd_en),
    .raddr_i (rd_q),
    .rdata_o (rdata_o)
  );

endmodule

// ===== rtl/key_debounce_repeat_event_fifo.sv =====
// Top level of the key debounce / auto-repeat / event FIFO block.
// Depends on kdr_pkg, kdr_if, kdr_cfg, kdr_scan, kdr_fifo, assert_macros.svh.
//
// Usage:
//   in_i carries one transaction per item: cmd tick (sample key_levels,
//   four active-low pins) or cmd pop (dequeue one key event).
//   out_o returns exactly one transaction per accepted item, in order:
//   for a pop, event_valid/event_key/event_kind of the dequeued event (all
//   zero when the FIFO is empty); for a tick, event_dropped flags a lost
//   event because the FIFO was full.
//   The APB port holds debounce_ticks at byte address 0 and repeat_ticks
//   at byte address 4; write it only while the block is idle.
// Timing:
//   The result of an accepted item is registered and is on out_o in the cycle after
//   acceptance. One item is accepted every cycle while the result register is free or
//   drained; the state update and FIFO access lie between handshake and result register.
// Reset:
//   rst_ni clears the scanner to idle, empties the FIFO and loads the
//   register defaults (20 and 250). No clearing pass is needed.
// Stall:
//   A result register sits on out_o; in_i stays ready while it is empty or
//   being taken, so a stalled receiver holds the block after one item.
`include "assert_macros.svh"

module key_debounce_repeat_event_fifo #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kdr_in_if.sink                     in_i,
  kdr_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kdr_pkg::CFG_AW-1:0] paddr,
  input  logic [kdr_pkg::CFG_DW-1:0] pwdata,
  output logic [kdr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  logic [kdr_pkg::TICK_W-1:0] debounce_ticks;
  logic [kdr_pkg::TICK_W-1:0] repeat_ticks;
  logic                       in_fire;
  logic                       tick_fire;
  logic                       pop_fire;
  kdr_pkg::push_t             push;
  kdr_pkg::fifo_stat_t        fifo_stat;
  logic [kdr_pkg::EVT_W-1:0]  fifo_rdata;

  logic out_valid_q, out_valid_d;
  logic pop_valid_q, pop_valid_d;
  logic dropped_q, dropped_d;

  // Input handshake: free result slot or the slot is being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign tick_fire  = in_fire && (in_i.cmd == kdr_pkg::CMD_TICK);
  assign pop_fire   = in_fire && (in_i.cmd == kdr_pkg::CMD_POP);

  kdr_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .debounce_ticks_o (debounce_ticks),
    .repeat_ticks_o   (repeat_ticks)
  );

  kdr_scan u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (tick_fire),
    .key_levels_i     (in_i.key_levels),
    .debounce_ticks_i (debounce_ticks),
    .repeat_ticks_i   (repeat_ticks),
    .push_o           (push)
  );

  kdr_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop_fire),
    .stat_o  (fifo_stat),
    .rdata_o (fifo_rdata)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    pop_valid_d = pop_valid_q;
    dropped_d   = dropped_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      pop_valid_d = pop_fire && !fifo_stat.empty;
      dropped_d   = push.push && fifo_stat.full;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pop_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pop_valid_q <= pop_valid_d;
      dropped_q   <= dropped_d;
    end
  end

  // Event fields come from the RAM read register, held until the next pop
  assign out_o.valid         = out_valid_q;
  assign out_o.event_valid   = pop_valid_q;
  assign out_o.event_key     = pop_valid_q ? fifo_rdata[kdr_pkg::EVT_W-1:2] : kdr_pkg::CODE_NONE;
  assign out_o.event_kind    = pop_valid_q ? fifo_rdata[1:0] : kdr_pkg::KIND_PRESSED;
  assign out_o.event_dropped = dropped_q;

  // Checks
  `KDR_ASSERT_IMP(a_pop_no_drop, clk_i, rst_ni, out_valid_q && pop_valid_q, !dropped_q,
    "popped event result also flags a drop")
  `KDR_ASSERT_NXT(a_pop_returns, clk_i, rst_ni, pop_fire && !fifo_stat.empty,
    out_valid_q && pop_valid_q, "pop of a non-empty FIFO returned no event")
  `KDR_ASSERT_NXT(a_push_lands, clk_i, rst_ni, tick_fire && push.push && !fifo_stat.full,
    !fifo_stat.empty, "accepted event push left the FIFO empty")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the key debounce / auto-repeat / event queue block.
// Depends on kdr_pkg, kdr_in_if/kdr_out_if and key_debounce_repeat_event_fifo.
module tb_top;

  localparam int unsigned RING_DEPTH = 4;

  logic clk_i;
  logic rst_ni;

  // APB configuration port
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [kdr_pkg::CFG_AW-1:0] paddr;
  logic [kdr_pkg::CFG_DW-1:0] pwdata;
  logic [kdr_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  kdr_in_if  in_if ();
  kdr_out_if out_if ();

  key_debounce_repeat_event_fifo #(
    .FIFO_DEPTH (RING_DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // One output transaction as the block reports it
  typedef struct packed {
    logic                      valid;
    logic [kdr_pkg::KEY_W-1:0] key;
    kdr_pkg::kind_e            kind;
    logic                      dropped;
  } key_report_t;

  key_report_t due_reports_q[$];

  // Shadow of the block's timing registers and scanner / queue state
  logic [kdr_pkg::TICK_W-1:0] cfg_debounce = kdr_pkg::DEBOUNCE_RST;
  logic [kdr_pkg::TICK_W-1:0] cfg_repeat   = kdr_pkg::REPEAT_RST;
  kdr_pkg::phase_e            scan_ph      = kdr_pkg::PH_IDLE;
  logic [kdr_pkg::KEY_W-1:0]  latched_key  = kdr_pkg::CODE_NONE;
  logic [kdr_pkg::TICK_W-1:0] tick_count   = '0;
  logic [kdr_pkg::KEY_W-1:0]  ring_key [RING_DEPTH];
  kdr_pkg::kind_e             ring_kind [RING_DEPTH];
  int unsigned                rd_ptr = 0;
  int unsigned                wr_ptr = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Run statistics
  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned pops_sent      = 0;
  int unsigned popped_events  = 0;
  int unsigned dropped_events = 0;
  int unsigned settings_seen  = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ERROR %s", $realtime, msg);
  endfunction

  // Enqueue into the shadow ring; one slot always stays free
  function automatic logic push_key_event(input logic [kdr_pkg::KEY_W-1:0] key,
                                          input kdr_pkg::kind_e kind);
    int unsigned nxt;
    nxt = (wr_ptr + 1) % RING_DEPTH;
    if (nxt == rd_ptr) return 1'b1;
    ring_key[wr_ptr]  = key;
    ring_kind[wr_ptr] = kind;
    wr_ptr = nxt;
    return 1'b0;
  endfunction

  // Advance the shadow state by one item and return what the block must report
  function automatic key_report_t predict_report(input logic cmd, input logic [3:0] lv);
    key_report_t               rep;
    logic [kdr_pkg::KEY_W-1:0] code;
    rep = '0;
    if (cmd == kdr_pkg::CMD_POP) begin
      if (rd_ptr != wr_ptr) begin
        rep.valid = 1'b1;
        rep.key   = ring_key[rd_ptr];
        rep.kind  = ring_kind[rd_ptr];
        rd_ptr    = (rd_ptr + 1) % RING_DEPTH;
      end
      return rep;
    end
    // lowest pin pulled low wins
    casez (lv)
      4'b???0: code = kdr_pkg::CODE_SET;
      4'b??01: code = kdr_pkg::CODE_PLUS;
      4'b?011: code = kdr_pkg::CODE_MINUS;
      4'b0111: code = kdr_pkg::CODE_RETURN;
      default: code = kdr_pkg::CODE_NONE;
    endcase
    if (scan_ph != kdr_pkg::PH_IDLE && tick_count != kdr_pkg::ELAPSED_MAX) tick_count++;
    case (scan_ph)
      kdr_pkg::PH_IDLE: begin
        if (code != kdr_pkg::CODE_NONE) begin
          latched_key = code;
          tick_count  = '0;
          scan_ph     = kdr_pkg::PH_DEBOUNCE;
        end
      end
      kdr_pkg::PH_DEBOUNCE: begin
        if (tick_count >= cfg_debounce) begin
          if (code == latched_key) begin
            rep.dropped = push_key_event(latched_key, kdr_pkg::KIND_PRESSED);
            tick_count  = '0;
            scan_ph     = kdr_pkg::PH_HELD;
          end else begin
            scan_ph = kdr_pkg::PH_IDLE;  // bounce
          end
        end
      end
      kdr_pkg::PH_HELD: begin
        if (code == kdr_pkg::CODE_NONE) begin
          tick_count = '0;
          scan_ph    = kdr_pkg::PH_RELEASE;
        end else if (tick_count > cfg_repeat) begin
          rep.dropped = push_key_event(latched_key, kdr_pkg::KIND_REPEATED);
          tick_count  = '0;
        end
      end
      default: begin
        if (tick_count >= cfg_debounce) begin
          if (code == kdr_pkg::CODE_NONE) begin
            rep.dropped = push_key_event(latched_key, kdr_pkg::KIND_RELEASED);
            scan_ph     = kdr_pkg::PH_IDLE;
          end else begin
            tick_count = '0;
          end
        end
      end
    endcase
    return rep;
  endfunction

  // Result side: check each transaction, then pick next cycle's ready
  always @(posedge clk_i) begin
    key_report_t got;
    key_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.valid   = out_if.event_valid;
      got.key     = out_if.event_key;
      got.kind    = kdr_pkg::kind_e'(out_if.event_kind);
      got.dropped = out_if.event_dropped;
      if (due_reports_q.size() == 0) begin
        note_failure($sformatf("unexpected result v=%0b key=%0d kind=%0d drop=%0b",
                               got.valid, got.key, got.kind, got.dropped));
      end else begin
        want = due_reports_q.pop_front();
        if (got !== want) begin
          note_failure($sformatf({"result mismatch: exp v=%0b key=%0d kind=%0d drop=%0b",
                                  " got v=%0b key=%0d kind=%0d drop=%0b"},
                                 want.valid, want.key, want.kind, want.dropped,
                                 got.valid, got.key, got.kind, got.dropped));
        end
        if (want.valid) popped_events++;
        if (want.dropped) dropped_events++;
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one item and record its expected result once it is accepted
  task automatic send_item(input logic cmd, input logic [3:0] lv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.key_levels <= lv;
    do @(posedge clk_i); while (!in_if.ready);
    due_reports_q.push_back(predict_report(cmd, lv));
    items_sent++;
    if (cmd == kdr_pkg::CMD_POP) pops_sent++;
  endtask

  // Stop sending and wait until every expected result is back
  task automatic drain_reports();
    in_if.valid <= 1'b0;
    while (due_reports_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_cycle(input logic wr, input logic idx,
                           input logic [kdr_pkg::CFG_DW-1:0] wdata,
                           output logic [kdr_pkg::CFG_DW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_timing_reg(input logic idx, input logic [kdr_pkg::TICK_W-1:0] value);
    logic [kdr_pkg::CFG_DW-1:0] rd;
    apb_cycle(1'b0, idx, '0, rd);
    if (rd !== kdr_pkg::CFG_DW'(value))
      note_failure($sformatf("register %0d reads %0h, expected %0h", idx, rd, value));
  endtask

  task automatic write_timing_reg(input logic idx, input logic [kdr_pkg::TICK_W-1:0] value);
    logic [kdr_pkg::CFG_DW-1:0] rd;
    apb_cycle(1'b1, idx, kdr_pkg::CFG_DW'(value), rd);
    check_timing_reg(idx, value);
  endtask

  // Reprogram both timing registers with the block drained
  task automatic set_timing(input logic [kdr_pkg::TICK_W-1:0] dbn,
                            input logic [kdr_pkg::TICK_W-1:0] rpt);
    drain_reports();
    write_timing_reg(kdr_pkg::REG_DEBOUNCE, dbn);
    write_timing_reg(kdr_pkg::REG_REPEAT, rpt);
    cfg_debounce = dbn;
    cfg_repeat   = rpt;
    settings_seen++;
  endtask

  task automatic test_register_defaults();
    check_timing_reg(kdr_pkg::REG_DEBOUNCE, kdr_pkg::DEBOUNCE_RST);
    check_timing_reg(kdr_pkg::REG_REPEAT, kdr_pkg::REPEAT_RST);
  endtask

  // One full press / repeat / release cycle at the reset timing
  task automatic test_default_timing();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (30) send_item(kdr_pkg::CMD_TICK, 4'b0111);
    repeat (260) send_item(kdr_pkg::CMD_TICK, 4'b0111);
    repeat (25) send_item(kdr_pkg::CMD_TICK, 4'b1111);
    repeat (4) send_item(kdr_pkg::CMD_POP, 4'b1111);
  endtask

  // Short hand-picked sequence at the fastest timing
  task automatic test_directed_cases();
    set_timing(16'd1, 16'd1);
    send_item(kdr_pkg::CMD_POP, 4'b0000);    // pop from an empty queue
    send_item(kdr_pkg::CMD_TICK, 4'b1111);   // nothing pressed
    send_item(kdr_pkg::CMD_TICK, 4'b1110);   // set starts debouncing
    send_item(kdr_pkg::CMD_TICK, 4'b0000);   // all low, set still wins: pressed
    send_item(kdr_pkg::CMD_TICK, 4'b0000);
    send_item(kdr_pkg::CMD_TICK, 4'b0000);   // repeat
    send_item(kdr_pkg::CMD_TICK, 4'b1101);   // other key while held
    send_item(kdr_pkg::CMD_TICK, 4'b1101);   // repeat still names set; queue now full
    send_item(kdr_pkg::CMD_TICK, 4'b1101);
    send_item(kdr_pkg::CMD_TICK, 4'b1101);   // repeat lost on the full queue
    send_item(kdr_pkg::CMD_TICK, 4'b1111);   // release check
    send_item(kdr_pkg::CMD_TICK, 4'b1111);   // released, lost as well
    repeat (4) send_item(kdr_pkg::CMD_POP, 4'b1111);
    send_item(kdr_pkg::CMD_TICK, 4'b1011);   // minus starts debouncing
    send_item(kdr_pkg::CMD_TICK, 4'b0111);   // return instead: bounce back to idle
    send_item(kdr_pkg::CMD_TICK, 4'b0111);
    send_item(kdr_pkg::CMD_TICK, 4'b0111);   // return pressed
    send_item(kdr_pkg::CMD_TICK, 4'b1111);
    send_item(kdr_pkg::CMD_TICK, 4'b1011);   // key back during release check
    send_item(kdr_pkg::CMD_TICK, 4'b1111);   // released
    repeat (3) send_item(kdr_pkg::CMD_POP, 4'b0101);
  endtask

  // Largest timing: a short press never gets through debounce, no events
  task automatic test_counter_saturation();
    set_timing(16'hFFFF, 16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (40) send_item(kdr_pkg::CMD_TICK, 4'b1101);
    repeat (20) send_item(kdr_pkg::CMD_TICK, 4'b1111);
    repeat (2) send_item(kdr_pkg::CMD_POP, 4'b1111);
  endtask

  // Press episodes with random keys and lengths, pops and pin noise mixed in
  task automatic test_random_traffic();
    int unsigned idle_pct [4] = '{0, 47, 0, 38};
    int unsigned stall_pct [4] = '{0, 0, 47, 38};
    int unsigned sent;
    int unsigned key_pick;
    int unsigned hold_len;
    int unsigned rel_len;
    int unsigned r;
    logic [3:0]  lv;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 0) set_timing(16'd1, 16'd1);
      else set_timing(kdr_pkg::TICK_W'($urandom_range(1, 8)),
                      kdr_pkg::TICK_W'($urandom_range(1, 16)));
      send_idle_pct  = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      sent = 0;
      while (sent < 320) begin
        key_pick = $urandom_range(1, 4);
        hold_len = $urandom_range(0, cfg_debounce + 3 * cfg_repeat + 4);
        rel_len  = $urandom_range(0, cfg_debounce + 4);
        for (int n = 0; n < hold_len + rel_len; n++) begin
          r = $urandom_range(99);
          if (r < 22) begin
            send_item(kdr_pkg::CMD_POP, 4'($urandom));
          end else if (r < 30) begin
            send_item(kdr_pkg::CMD_TICK, 4'($urandom));
          end else if (n < hold_len) begin
            // chosen pin low, higher-priority pins high, the rest random
            lv = 4'($urandom) | 4'((1 << (key_pick - 1)) - 1);
            lv[key_pick-1] = 1'b0;
            send_item(kdr_pkg::CMD_TICK, lv);
          end else begin
            send_item(kdr_pkg::CMD_TICK, 4'b1111);
          end
          sent++;
          if (ph == 2 && sent == 200) drain_reports();
        end
      end
    end
    drain_reports();
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.cmd        = kdr_pkg::CMD_TICK;
    in_if.key_levels = 4'b1111;
    out_if.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rst_ni           = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_register_defaults();
    test_default_timing();
    test_directed_cases();
    test_counter_saturation();
    test_random_traffic();

    fail_count += due_reports_q.size();
    $display("Ran %0d items (%0d pops) over %0d timing settings and four idle/stall mixes.",
             items_sent, pops_sent, settings_seen);
    $display("Queue delivered %0d key events; %0d events were lost on a full queue.",
             popped_events, dropped_events);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
